[rtl/bias_activation_float32_macros.svh]
// ----------------------------------------------------------------------------
// bias_activation_float32 assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BIAS_ACTIVATION_FLOAT32_MACROS_SVH
`define BIAS_ACTIVATION_FLOAT32_MACROS_SVH
`ifndef SYNTHESIS
`define BAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("baf assertion failed");
`define BAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("baf assertion failed");
`else
`define BAF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BAF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/baf_pkg.sv]
// ----------------------------------------------------------------------------
// baf_pkg
// shared constants, types and float compare helpers for bias/activation
// ----------------------------------------------------------------------------
package baf_pkg;

	localparam logic [31:0] QNAN_BITS     = 32'h7FC0_0000;
	localparam logic [31:0] ONE_BITS      = 32'h3F80_0000;
	localparam logic [31:0] POS_ZERO_BITS = 32'h0000_0000;
	localparam logic [31:0] NEG_ZERO_BITS = 32'h8000_0000;
	localparam logic [31:0] CLIP_MIN_RST  = 32'hFF80_0000;
	localparam logic [31:0] CLIP_MAX_RST  = 32'h7F80_0000;

	typedef enum logic [2:0] {
		ACT_IDENTITY = 3'd0,
		ACT_RELU     = 3'd1,
		ACT_LEAKY    = 3'd2,
		ACT_CLIP     = 3'd3,
		ACT_HSIG     = 3'd4
	} act_kind_t;

	typedef enum logic [2:0] {
		REG_KIND     = 3'd0,
		REG_BIAS_EN  = 3'd1,
		REG_ALPHA    = 3'd2,
		REG_BETA     = 3'd3,
		REG_CLIP_MIN = 3'd4,
		REG_CLIP_MAX = 3'd5
	} reg_idx_t;

	// element carried alongside the arithmetic
	typedef struct packed {
		logic [31:0] x;
		logic        row_end;
		logic        matrix_end;
	} tag_t;

	function automatic logic is_nan(input logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	function automatic logic is_inf(input logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
	endfunction

	function automatic logic is_zero(input logic [31:0] b);
		return b[30:0] == 31'd0;
	endfunction

	// ordered a < b, false on any nan, +0 == -0
	function automatic logic flt(input logic [31:0] a, input logic [31:0] b);
		logic r;
		r = 1'b0;
		if (is_nan(a) || is_nan(b)) begin
			r = 1'b0;
		end else if (a[31] && !b[31]) begin
			r = !((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
		end else if (!a[31] && b[31]) begin
			r = 1'b0;
		end else if (!a[31]) begin
			r = a[30:0] < b[30:0];
		end else begin
			r = a[30:0] > b[30:0];
		end
		return r;
	endfunction

	// leading zero count, 64 when the word is zero
	function automatic logic [6:0] lzc64(input logic [63:0] w);
		logic [6:0] n;
		n = 7'd64;
		for (int i = 0; i < 64; i++) begin
			if (w[i]) begin
				n = 7'(63 - i);
			end
		end
		return n;
	endfunction

endpackage

[rtl/baf_fma.sv]
// ----------------------------------------------------------------------------
// baf_fma
// six stage binary32 fused multiply-add, round to nearest even, subnormals kept
// ----------------------------------------------------------------------------
`include "bias_activation_float32_macros.svh"

module baf_fma import baf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_v,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic        bypass,
	input  tag_t        tag_in,
	output logic        out_v,
	output logic [31:0] result,
	output tag_t        tag_out
);

	// ---------------- stage 1: unpack, specials, multiply
	logic               sp, sc;
	logic [7:0]         efa, efb, efc;
	logic [23:0]        ma, mb, mc;
	logic signed [10:0] ea, eb, ec;
	logic               spec1;
	logic [31:0]        sbits1;

	always_comb begin
		sp  = a[31] ^ b[31];
		sc  = c[31];
		efa = a[30:23] | {7'd0, ~|a[30:23]};
		efb = b[30:23] | {7'd0, ~|b[30:23]};
		efc = c[30:23] | {7'd0, ~|c[30:23]};
		ma  = {|a[30:23], a[22:0]};
		mb  = {|b[30:23], b[22:0]};
		mc  = {|c[30:23], c[22:0]};
		ea  = $signed({3'b000, efa}) - 11'sd150;
		eb  = $signed({3'b000, efb}) - 11'sd150;
		ec  = $signed({3'b000, efc}) - 11'sd150;
		spec1  = 1'b1;
		sbits1 = QNAN_BITS;
		if (bypass) begin
			sbits1 = a;
		end else if (is_nan(a) || is_nan(b) || is_nan(c)) begin
			sbits1 = QNAN_BITS;
		end else if (is_inf(a) || is_inf(b)) begin
			if (is_zero(a) || is_zero(b)) begin
				sbits1 = QNAN_BITS;
			end else if (is_inf(c) && (sc != sp)) begin
				sbits1 = QNAN_BITS;
			end else begin
				sbits1 = {sp, 8'hFF, 23'd0};
			end
		end else if (is_inf(c)) begin
			sbits1 = c;
		end else if (is_zero(a) || is_zero(b)) begin
			sbits1 = is_zero(c) ? {sp & sc, 31'd0} : c;
		end else begin
			spec1 = 1'b0;
		end
	end

	logic               v_s1, spec_s1, sp_s1, sc_s1, czero_s1;
	logic [31:0]        sbits_s1;
	logic [47:0]        prod_s1;
	logic signed [10:0] ep_s1, ec_s1;
	logic [23:0]        mc_s1;
	tag_t               tag_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1  <= spec1;
			sbits_s1 <= sbits1;
			sp_s1    <= sp;
			sc_s1    <= sc;
			czero_s1 <= is_zero(c);
			prod_s1  <= ma * mb;
			ep_s1    <= ea + eb;
			ec_s1    <= ec;
			mc_s1    <= mc;
			tag_s1   <= tag_in;
		end
	end

	// ---------------- stage 2: normalize product and addend to bit 61
	logic [6:0]         lzp, lzm;
	logic [47:0]        pshl;
	logic [23:0]        mshl;
	logic signed [11:0] ep2, ec2;

	always_comb begin
		lzp  = lzc64({prod_s1, 16'hFFFF});
		lzm  = lzc64({mc_s1, 40'hFF_FFFF_FFFF});
		pshl = prod_s1 << lzp[5:0];
		mshl = mc_s1 << lzm[5:0];
		ep2  = {ep_s1[10], ep_s1} - $signed({5'd0, lzp}) - 12'sd14;
		ec2  = {ec_s1[10], ec_s1} - $signed({5'd0, lzm}) - 12'sd38;
	end

	logic               v_s2, spec_s2, sp_s2, sc_s2, czero_s2;
	logic [31:0]        sbits_s2;
	logic [63:0]        pn_s2, cn_s2;
	logic signed [11:0] ep_s2, ec_s2;
	tag_t               tag_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s2  <= spec_s1;
			sbits_s2 <= sbits_s1;
			sp_s2    <= sp_s1;
			sc_s2    <= sc_s1;
			czero_s2 <= czero_s1;
			pn_s2    <= {2'b00, pshl, 14'd0};
			cn_s2    <= czero_s1 ? 64'd0 : {2'b00, mshl, 38'd0};
			ep_s2    <= ep2;
			ec_s2    <= ec2;
			tag_s2   <= tag_s1;
		end
	end

	// ---------------- stage 3: align smaller operand with sticky, add or subtract
	logic               pbig, sgn3, zero3;
	logic [63:0]        big, small_op, small_sh, sum3;
	logic signed [11:0] ebig, dexp;

	always_comb begin
		pbig = czero_s2 || (ep_s2 > ec_s2) || ((ep_s2 == ec_s2) && (pn_s2 >= cn_s2));
		big      = pbig ? pn_s2 : cn_s2;
		small_op = pbig ? cn_s2 : pn_s2;
		ebig     = pbig ? ep_s2 : ec_s2;
		dexp     = pbig ? (ep_s2 - ec_s2) : (ec_s2 - ep_s2);
		sgn3     = pbig ? sp_s2 : sc_s2;
		if (czero_s2) begin
			small_sh = 64'd0;
		end else if (dexp >= 12'sd63) begin
			small_sh = 64'd1;
		end else begin
			small_sh = (small_op >> dexp[5:0])
				| {63'd0, |(small_op & ((64'd1 << dexp[5:0]) - 64'd1))};
		end
		sum3  = (sp_s2 == sc_s2) ? (big + small_sh) : (big - small_sh);
		zero3 = (sum3 == 64'd0);
	end

	logic               v_s3, spec_s3, sgn_s3;
	logic [31:0]        sbits_s3;
	logic [63:0]        sum_s3;
	logic signed [11:0] e_s3;
	tag_t               tag_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s3  <= spec_s2 | zero3;
			sbits_s3 <= spec_s2 ? sbits_s2 : POS_ZERO_BITS;
			sgn_s3   <= sgn3;
			sum_s3   <= sum3;
			e_s3     <= ebig;
			tag_s3   <= tag_s2;
		end
	end

	// ---------------- stage 4: normalize sum to bit 62
	logic [6:0] lzs, nsh;

	always_comb begin
		lzs = lzc64(sum_s3);
		nsh = lzs - 7'd1;
	end

	logic               v_s4, spec_s4, sgn_s4;
	logic [31:0]        sbits_s4;
	logic [63:0]        norm_s4;
	logic signed [11:0] e_s4;
	tag_t               tag_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s4  <= spec_s3;
			sbits_s4 <= sbits_s3;
			sgn_s4   <= sgn_s3;
			norm_s4  <= sum_s3 << nsh[5:0];
			e_s4     <= e_s3 - $signed({5'd0, nsh});
			tag_s4   <= tag_s3;
		end
	end

	// ---------------- stage 5: shift to result precision, round and sticky bits
	logic signed [11:0] shreq;
	logic               uflow5, rnd5, stk5;
	logic [5:0]         shamt, shm1;
	logic [23:0]        m5;

	always_comb begin
		shreq  = -12'sd149 - e_s4;
		uflow5 = shreq > 12'sd63;
		shamt  = (shreq > 12'sd39) ? shreq[5:0] : 6'd39;
		shm1   = shamt - 6'd1;
		m5     = 24'(norm_s4 >> shamt);
		rnd5   = norm_s4[shm1];
		stk5   = |(norm_s4 & ((64'd1 << shm1) - 64'd1));
	end

	logic               v_s5, spec_s5, sgn_s5, uflow_s5, rnd_s5, stk_s5;
	logic [31:0]        sbits_s5;
	logic [23:0]        m_s5;
	logic signed [11:0] qe_s5;
	tag_t               tag_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s5  <= spec_s4;
			sbits_s5 <= sbits_s4;
			sgn_s5   <= sgn_s4;
			uflow_s5 <= uflow5;
			rnd_s5   <= rnd5;
			stk_s5   <= stk5;
			m_s5     <= m5;
			qe_s5    <= e_s4 + $signed({6'd0, shamt});
			tag_s5   <= tag_s4;
		end
	end

	// ---------------- stage 6: increment, renormalize, pack
	logic               inc6;
	logic [24:0]        mr6;
	logic [23:0]        mf6;
	logic signed [11:0] qe6, bexp6;
	logic [31:0]        res6;

	always_comb begin
		inc6  = rnd_s5 & (stk_s5 | m_s5[0]);
		mr6   = {1'b0, m_s5} + {24'd0, inc6};
		mf6   = mr6[24] ? mr6[24:1] : mr6[23:0];
		qe6   = mr6[24] ? (qe_s5 + 12'sd1) : qe_s5;
		bexp6 = qe6 + 12'sd150;
		if (spec_s5) begin
			res6 = sbits_s5;
		end else if (uflow_s5) begin
			res6 = {sgn_s5, 31'd0};
		end else if (!mf6[23]) begin
			res6 = {sgn_s5, 8'd0, mf6[22:0]};
		end else if (bexp6 >= 12'sd255) begin
			res6 = {sgn_s5, 8'hFF, 23'd0};
		end else begin
			res6 = {sgn_s5, bexp6[7:0], mf6[22:0]};
		end
	end

	logic        v_s6;
	logic [31:0] res_s6;
	tag_t        tag_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6 <= res6;
			tag_s6 <= tag_s5;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	logic [5:0] vld;
	assign vld     = {v_s6, v_s5, v_s4, v_s3, v_s2, v_s1};
	assign out_v   = v_s6;
	assign result  = res_s6;
	assign tag_out = tag_s6;

	`BAF_ASSERT_NXT(a_fma_hold, clk, arst_n, !en, $stable(vld))
	`BAF_ASSERT_IMP(a_fma_pnorm, clk, arst_n, v_s2 && !spec_s2, pn_s2[61] && !pn_s2[62] && !pn_s2[63])
	`BAF_ASSERT_IMP(a_fma_snorm, clk, arst_n, v_s4 && !spec_s4, norm_s4[62] && !norm_s4[63])

endmodule

[rtl/baf_act.sv]
// ----------------------------------------------------------------------------
// baf_act
// activation select and clamps, output register of the block
// ----------------------------------------------------------------------------
`include "bias_activation_float32_macros.svh"

module baf_act import baf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_v,
	input  logic [31:0] y,
	input  tag_t        tag_in,
	input  logic [2:0]  kind,
	input  logic [31:0] clip_min,
	input  logic [31:0] clip_max,
	output logic        out_v,
	output logic [31:0] activated,
	output logic        row_done,
	output logic        matrix_done
);

	logic [31:0] x, t, r;

	always_comb begin
		x = tag_in.x;
		t = x;
		r = x;
		unique case (kind)
			ACT_RELU: begin
				r = flt(x, POS_ZERO_BITS) ? POS_ZERO_BITS : x;
			end
			ACT_LEAKY: begin
				r = flt(POS_ZERO_BITS, x) ? x : y;
			end
			ACT_CLIP: begin
				t = flt(x, clip_min) ? clip_min : x;
				r = flt(clip_max, t) ? clip_max : t;
			end
			ACT_HSIG: begin
				t = flt(ONE_BITS, y) ? ONE_BITS : y;
				r = flt(t, POS_ZERO_BITS) ? POS_ZERO_BITS : t;
			end
			default: begin
				r = x;
			end
		endcase
	end

	logic        v_q;
	logic [31:0] res_q;
	logic        row_q, mat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= r;
			row_q <= tag_in.row_end;
			mat_q <= tag_in.matrix_end;
		end
	end

	assign out_v       = v_q;
	assign activated   = res_q;
	assign row_done    = row_q;
	assign matrix_done = mat_q;

	// hard sigmoid never leaves a non-nan above one
	`BAF_ASSERT_NXT(a_act_hsig, clk, arst_n, en && in_v && (kind == ACT_HSIG), !(!res_q[31] && (res_q[30:0] > ONE_BITS[30:0]) && (res_q[30:0] <= 31'h7F80_0000)))

endmodule

[rtl/bias_activation_float32.sv]
// ----------------------------------------------------------------------------
// bias_activation_float32
// fused bias add and activation on a stream of binary32 elements
// ----------------------------------------------------------------------------
// usage:
//   configuration is written through cfg_write/cfg_index/cfg_data while the
//   stream is idle; index 0 kind, 1 bias enable, 2 alpha, 3 beta, 4 clip min,
//   5 clip max. writes to other indexes are ignored.
//   input beats (value, row_bias, row_end, matrix_end) are taken when
//   in_valid is high and in_stall low; result beats (activated, row_done,
//   matrix_done) leave when out_valid is high and out_stall low.
//   the pipe is six stages for the bias fma, six for the activation fma
//   and one for the select and clamp stage, which is the output register.
//   throughput is one beat per cycle while no result is stalled at the output.
//   the whole pipe advances together; while a result sits stalled at the
//   output, in_stall is high and every stage holds its contents.
//   reset clears all valid bits and loads the register reset values
//   (identity, bias off, alpha and beta zero, clip bounds -inf and +inf).
// ----------------------------------------------------------------------------
module bias_activation_float32 import baf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] value,
	input  logic [31:0] row_bias,
	input  logic        row_end,
	input  logic        matrix_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] activated,
	output logic        row_done,
	output logic        matrix_done
);

	logic [2:0]  kind_q;
	logic        bias_en_q;
	logic [31:0] alpha_q, beta_q, clip_min_q, clip_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q     <= ACT_IDENTITY;
			bias_en_q  <= 1'b0;
			alpha_q    <= POS_ZERO_BITS;
			beta_q     <= POS_ZERO_BITS;
			clip_min_q <= CLIP_MIN_RST;
			clip_max_q <= CLIP_MAX_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_KIND:     kind_q     <= cfg_data[2:0];
				REG_BIAS_EN:  bias_en_q  <= cfg_data[0];
				REG_ALPHA:    alpha_q    <= cfg_data;
				REG_BETA:     beta_q     <= cfg_data;
				REG_CLIP_MIN: clip_min_q <= cfg_data;
				REG_CLIP_MAX: clip_max_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	tag_t        tag_in, tag_b, tag_m, tag_a;
	logic        v_b, v_a;
	logic [31:0] x_b, y_a, c_a;
	logic        byp_a;

	assign tag_in = '{x: value, row_end: row_end, matrix_end: matrix_end};

	baf_fma u_bias (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (in_valid),
		.a       (value),
		.b       (ONE_BITS),
		.c       (row_bias),
		.bypass  (!bias_en_q),
		.tag_in  (tag_in),
		.out_v   (v_b),
		.result  (x_b),
		.tag_out (tag_b)
	);

	// the second unit only matters for leaky relu and hard sigmoid
	assign c_a   = (kind_q == ACT_HSIG) ? beta_q : NEG_ZERO_BITS;
	assign byp_a = !((kind_q == ACT_LEAKY) || (kind_q == ACT_HSIG));
	assign tag_m = '{x: x_b, row_end: tag_b.row_end, matrix_end: tag_b.matrix_end};

	baf_fma u_act_fma (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_b),
		.a       (x_b),
		.b       (alpha_q),
		.c       (c_a),
		.bypass  (byp_a),
		.tag_in  (tag_m),
		.out_v   (v_a),
		.result  (y_a),
		.tag_out (tag_a)
	);

	baf_act u_sel (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_v        (v_a),
		.y           (y_a),
		.tag_in      (tag_a),
		.kind        (kind_q),
		.clip_min    (clip_min_q),
		.clip_max    (clip_max_q),
		.out_v       (out_valid),
		.activated   (activated),
		.row_done    (row_done),
		.matrix_done (matrix_done)
	);

endmodule

[tb/bias_activation_float32_tb.sv]
// ----------------------------------------------------------------------------
// bias_activation_float32_tb
// drives binary32 elements with row biases through the bias/activation pipe
// under every activation setting, predicts each result bit for bit in integer
// arithmetic and compares result beats in order, with random gaps and stalls
// ----------------------------------------------------------------------------
module bias_activation_float32_tb;
	import baf_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] value;
	logic [31:0] row_bias;
	logic        row_end;
	logic        matrix_end;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] activated;
	logic        row_done;
	logic        matrix_done;

	typedef struct packed {
		logic [31:0] act;
		logic        rdone;
		logic        mdone;
	} act_beat_t;

	act_beat_t pending_acts[$];
	int        mismatches;
	int        hold_cycles;
	bit        burst_gaps;

	// predictor copy of the registers
	logic [2:0]  m_kind;
	logic        m_bias_en;
	logic [31:0] m_alpha;
	logic [31:0] m_beta;
	logic [31:0] m_cmin;
	logic [31:0] m_cmax;

	bias_activation_float32 DUT (
		.clk(clk), .arst_n(arst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .value(value),
		.row_bias(row_bias), .row_end(row_end), .matrix_end(matrix_end),
		.out_valid(out_valid), .out_stall(out_stall), .activated(activated),
		.row_done(row_done), .matrix_done(matrix_done)
	);

	always #10 clk = ~clk;

	function automatic bit f_nan(logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 0);
	endfunction

	function automatic bit f_inf(logic [31:0] b);
		return b[30:0] == 31'h7F800000;
	endfunction

	function automatic bit f_zero(logic [31:0] b);
		return b[30:0] == 0;
	endfunction

	function automatic bit ord_less(logic [31:0] a, logic [31:0] b);
		longint ka, kb;
		if (f_nan(a) || f_nan(b)) return 0;
		ka = a[30:0];
		kb = b[30:0];
		if (a[31]) ka = -ka;
		if (b[31]) kb = -kb;
		return ka < kb;
	endfunction

	function automatic void split_float(logic [31:0] b, output logic [63:0] m,
			output int e);
		if (b[30:23] == 0) begin
			m = {41'd0, b[22:0]};
			e = -149;
		end else begin
			m = {40'd0, 1'b1, b[22:0]};
			e = int'(b[30:23]) - 150;
		end
	endfunction

	function automatic logic [31:0] round_nearest(logic sgn, logic [63:0] s, int e);
		int sh, qe;
		logic [63:0] m, rem, half;
		if (s[63]) begin
			s = (s >> 1) | (s & 64'd1);
			e++;
		end
		while (s[63:62] == 0) begin
			s = s << 1;
			e--;
		end
		sh = 39;
		if (-149 - e > sh) sh = -149 - e;
		if (sh > 63) return {sgn, 31'd0};
		m = s >> sh;
		rem = s & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && m[0])) m++;
		qe = e + sh;
		if (m[24]) begin
			m = m >> 1;
			qe++;
		end
		if (m < 64'h800000) return {sgn, m[30:0]};
		if (qe + 150 >= 255) return {sgn, 31'h7F800000};
		return {sgn, 8'(qe + 150), m[22:0]};
	endfunction

	function automatic logic [31:0] fused_mul_add(logic [31:0] a, logic [31:0] b,
			logic [31:0] c);
		logic sp, sc, sgn;
		logic [63:0] ma, mb, mc, p, big, sml, s;
		int ea, eb, ec, ep, ebig, d;
		sp = a[31] ^ b[31];
		sc = c[31];
		if (f_nan(a) || f_nan(b) || f_nan(c)) return QNAN_BITS;
		if (f_inf(a) || f_inf(b)) begin
			if (f_zero(a) || f_zero(b)) return QNAN_BITS;
			if (f_inf(c) && sc != sp) return QNAN_BITS;
			return {sp, 31'h7F800000};
		end
		if (f_inf(c)) return c;
		if (f_zero(a) || f_zero(b)) begin
			if (f_zero(c)) return (sp && sc) ? NEG_ZERO_BITS : POS_ZERO_BITS;
			return c;
		end
		split_float(a, ma, ea);
		split_float(b, mb, eb);
		p = ma * mb;
		ep = ea + eb;
		if (f_zero(c)) return round_nearest(sp, p, ep);
		split_float(c, mc, ec);
		while (p[63:61] == 0) begin
			p = p << 1;
			ep--;
		end
		while (mc[63:61] == 0) begin
			mc = mc << 1;
			ec--;
		end
		if (ep > ec || (ep == ec && p >= mc)) begin
			big = p; sml = mc; ebig = ep; d = ep - ec; sgn = sp;
		end else begin
			big = mc; sml = p; ebig = ec; d = ec - ep; sgn = sc;
		end
		if (d >= 63) sml = 1;
		else sml = (sml >> d) | 64'((sml & ((64'd1 << d) - 1)) != 0);
		if (sp == sc) s = big + sml;
		else begin
			s = big - sml;
			if (s == 0) return POS_ZERO_BITS;
		end
		return round_nearest(sgn, s, ebig);
	endfunction

	function automatic logic [31:0] predict_activation(logic [31:0] v, logic [31:0] b);
		logic [31:0] x;
		x = v;
		if (m_bias_en) x = fused_mul_add(x, ONE_BITS, b);
		case (m_kind)
			ACT_RELU: begin
				if (ord_less(x, POS_ZERO_BITS)) x = POS_ZERO_BITS;
			end
			ACT_LEAKY: begin
				if (!ord_less(POS_ZERO_BITS, x)) x = fused_mul_add(x, m_alpha, NEG_ZERO_BITS);
			end
			ACT_CLIP: begin
				if (ord_less(x, m_cmin)) x = m_cmin;
				if (ord_less(m_cmax, x)) x = m_cmax;
			end
			ACT_HSIG: begin
				x = fused_mul_add(x, m_alpha, m_beta);
				if (ord_less(ONE_BITS, x)) x = ONE_BITS;
				if (ord_less(x, POS_ZERO_BITS)) x = POS_ZERO_BITS;
			end
			default: ;
		endcase
		return x;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// interesting binary32 patterns
	function automatic logic [31:0] pick_float();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 15))
			0: return {r[31], 31'd0};
			1: return {r[31], 31'h7F800000};
			2: return {r[31], 8'hFF, r[22:1], 1'b1};
			3: return {r[31], 8'd0, r[22:0]};
			4: return {r[31], 31'h7F7FFFFF};
			5: return {r[31], 8'(int'($urandom_range(100, 154))), r[22:0]};
			6: return {r[31], 8'(int'($urandom_range(1, 30))), r[22:0]};
			7: return {r[31], 31'h3F800000};
			default: return {r[31], 8'(int'($urandom_range(110, 140))), r[22:0]};
		endcase
	endfunction

	// cfg_write drops low after each write, which keeps back to back writes apart
	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_KIND:     m_kind    = data[2:0];
			REG_BIAS_EN:  m_bias_en = data[0];
			REG_ALPHA:    m_alpha   = data;
			REG_BETA:     m_beta    = data;
			REG_CLIP_MIN: m_cmin    = data;
			default:      m_cmax    = data;
		endcase
		@(posedge clk);
	endtask

	// in_valid stays high into the next beat when there is no gap
	task automatic send_element(logic [31:0] v, logic [31:0] b, logic re, logic me);
		int g;
		g = burst_gaps ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid   <= 1'b1;
		value      <= v;
		row_bias   <= b;
		row_end    <= re;
		matrix_end <= me;
		pending_acts.push_back('{predict_activation(v, b), re, me});
		do @(posedge clk); while (in_stall);
	endtask

	task automatic drain_pipe();
		in_valid <= 1'b0;
		while (pending_acts.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_random(int n);
		for (int i = 0; i < n; i++) begin
			send_element(pick_float(), pick_float(), $urandom_range(0, 1),
				$urandom_range(0, 7) == 0);
		end
	endtask

	task automatic test_directed();
		logic [31:0] specials[12];
		specials = '{32'h00000000, 32'h80000000, 32'h7F800000, 32'hFF800000,
			32'h7FC00001, 32'hFFFFFFFF, 32'h00000001, 32'h807FFFFF,
			32'h7F7FFFFF, 32'hFF7FFFFF, 32'h3F800000, 32'hBF800000};
		write_reg(REG_BIAS_EN, 32'd1);
		for (int k = 0; k < 12; k++)
			send_element(specials[k], specials[11 - k], k[0], k == 11);
		send_element(32'h7F7FFFFF, 32'h7F7FFFFF, 1'b1, 1'b0);
		send_element(32'h3F800000, 32'hBF800000, 1'b0, 1'b1);
		drain_pipe();
		write_reg(REG_BIAS_EN, 32'd0);
		for (int k = 0; k < ACT_HSIG + 4; k++) begin
			write_reg(REG_KIND, 32'(k));
			write_reg(REG_ALPHA, 32'h3E4CCCCD);
			write_reg(REG_BETA, 32'h3F000000);
			write_reg(REG_CLIP_MIN, 32'hBF800000);
			write_reg(REG_CLIP_MAX, 32'h7FC00000);
			send_element(32'hC0000000, 32'h0, 1'b0, 1'b0);
			send_element(32'h40000000, 32'h0, 1'b1, 1'b0);
			send_element(32'h7FC00123, 32'h0, 1'b1, 1'b1);
			drain_pipe();
		end
	endtask

	task automatic test_settings();
		for (int ph = 0; ph < 30; ph++) begin
			write_reg(REG_KIND, ph < 25 ? 32'(ph % 5) : 32'($urandom_range(5, 7)));
			write_reg(REG_BIAS_EN, $urandom_range(0, 1));
			write_reg(REG_ALPHA, ph % 3 == 0 ? 32'h3DCCCCCD : pick_float());
			write_reg(REG_BETA, ph % 3 == 0 ? 32'h3F000000 : pick_float());
			write_reg(REG_CLIP_MIN, ph == 7 ? CLIP_MIN_RST : pick_float());
			write_reg(REG_CLIP_MAX, ph == 7 ? CLIP_MAX_RST : pick_float());
			burst_gaps = ($urandom_range(0, 3) == 0);
			send_random(40);
			drain_pipe();
		end
		burst_gaps = 0;
	endtask

	task automatic test_backpressure();
		write_reg(REG_KIND, ACT_LEAKY);
		write_reg(REG_ALPHA, 32'hFFFFFFFF);
		hold_cycles = 60;
		burst_gaps = 1;
		send_random(100);
		burst_gaps = 0;
		drain_pipe();
		send_random(50);
	endtask

	// result side: stalls and the long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 25) ||
				($urandom_range(0, 199) == 0);
		end
	end

	always @(posedge clk) begin
		act_beat_t exp_beat;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_acts.size() == 0) begin
				$display("%0t: unexpected beat activated=%h", $time, activated);
				mismatches++;
			end else begin
				exp_beat = pending_acts.pop_front();
				if (activated !== exp_beat.act) begin
					$display("%0t: activated exp %h got %h", $time, exp_beat.act, activated);
					mismatches++;
				end
				if (row_done !== exp_beat.rdone) begin
					$display("%0t: row_done exp %b got %b", $time, exp_beat.rdone, row_done);
					mismatches++;
				end
				if (matrix_done !== exp_beat.mdone) begin
					$display("%0t: matrix_done exp %b got %b", $time, exp_beat.mdone,
						matrix_done);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#20000000;
		$display("bias_activation_float32_tb: errors");
		$finish;
	end

	initial begin
		clk = 0; arst_n = 0; cfg_write = 0; cfg_index = 0; cfg_data = 0;
		in_valid = 0; value = 0; row_bias = 0; row_end = 0; matrix_end = 0;
		out_stall = 0; mismatches = 0; hold_cycles = 0; burst_gaps = 0;
		m_kind = ACT_IDENTITY; m_bias_en = 0; m_alpha = 0; m_beta = 0;
		m_cmin = CLIP_MIN_RST; m_cmax = CLIP_MAX_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_settings();
		test_backpressure();
		drain_pipe();
		if (mismatches == 0 && pending_acts.size() == 0) begin
			$display("bias_activation_float32_tb: clean");
		end else begin
			$display("bias_activation_float32_tb: errors");
		end
		$finish;
	end

endmodule

[bias_activation_float32.f]
+incdir+rtl
rtl/baf_pkg.sv
rtl/baf_fma.sv
rtl/baf_act.sv
rtl/bias_activation_float32.sv
tb/bias_activation_float32_tb.sv
